[rtl/vtb_pkg.sv]
// package for the virtual timer bank: sizes, codes, channel entry layout
// and the handshake structs between the control and the tick divider
// no dependencies
package vtb_pkg;

  localparam int NUM_CHANNELS  = 4;
  localparam int TICK_FREQ_HZ  = 4;
  localparam int US_PER_SECOND = 1000000;

  // channel address width
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // match period times tick rate
  localparam int PROD_W = 32 + $clog2(TICK_FREQ_HZ + 1);
  // divisor width, quotient width and scaled reciprocal of the divisor
  localparam int DIV_W = $clog2(US_PER_SECOND + 1);
  localparam int QUO_W = PROD_W - DIV_W + 1;
  localparam longint RECIP_VAL = (longint'(1) << PROD_W) / longint'(US_PER_SECOND);

  localparam int IRQ_W = 4;
  localparam int IN_W  = 40;
  localparam int OUT_W = 40;

  // command codes
  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_START     = 3'd1,
    ACT_READ      = 3'd2,
    ACT_SET_MATCH = 3'd3,
    ACT_GET_FLAG  = 3'd4,
    ACT_SET_EN    = 3'd5,
    ACT_GET_EN    = 3'd6
  } action_t;

  // set match status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LONG  = 2'd1;
  localparam logic [1:0] ST_TOO_SHORT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_APPLY,
    S_TICK
  } state_t;

  // one channel as stored in the entry memory
  typedef struct packed {
    logic [31:0] count;
    logic [31:0] limit;
    logic        periodic;
    logic        enable;
    logic        flag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/vtb_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module vtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wa,
  input  logic [WIDTH-1:0]                              wd,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra,
  output logic [WIDTH-1:0]                              rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

[rtl/vtb_div.sv]
// divider by the microseconds-per-second constant: reciprocal multiply, back
// multiply and one correction step, each in its own registered stage; depends on vtb_pkg
module vtb_div
  import vtb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [PROD_W-1:0] DIVISOR = PROD_W'(US_PER_SECOND);
  localparam logic [DIV_W:0]    REM_LIM = (DIV_W + 1)'(US_PER_SECOND);
  localparam logic [QUO_W-1:0]  RECIP   = QUO_W'(RECIP_VAL);

  logic                    v0_r, v1_r, v2_r, done_r;
  logic [PROD_W-1:0]       x_r, x_nxt;
  logic [QUO_W-1:0]        est_r, est_nxt;
  logic [DIV_W:0]          rem_r, rem_nxt;
  logic [PROD_W-1:0]       quo_r, quo_nxt;
  logic [PROD_W+QUO_W-1:0] prod;
  logic [PROD_W-1:0]       back;
  logic [PROD_W-1:0]       diff;

  // estimate is the quotient or one below it, the remainder check fixes it
  always_comb begin
    x_nxt   = req.start ? req.dividend : x_r;
    prod    = (PROD_W + QUO_W)'(x_r) * (PROD_W + QUO_W)'(RECIP);
    est_nxt = prod[PROD_W+QUO_W-1:PROD_W];
    back    = PROD_W'(est_r) * DIVISOR;
    diff    = x_r - back;
    rem_nxt = diff[DIV_W:0];
    quo_nxt = PROD_W'(est_r) + PROD_W'(rem_r >= REM_LIM);
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v0_r   <= req.start;
      v1_r   <= v0_r;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    est_r <= est_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

[rtl/virtual_timer_bank.sv]
// virtual timer bank top level: request control, channel entry memory and
// tick conversion divider; depends on vtb_pkg, vtb_ram, vtb_div
// tick does one entry read-modify-write per channel; set match with a nonzero
// period also passes through the divider
// throughput: one request at a time; a waiting result holds the next request
// before its entry read. reset: valid bits
module virtual_timer_bank
  import vtb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // action[2:0], channel[4:3], match period[36:5], periodic[37],
  // clear_flag[38], enable_value[39]
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  // status[1:0], count_value[33:2], bit_value[34], irq_mask[38:35]
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tvalid,
  input  logic             out_tready
);

  state_t            state_r, state_nxt;
  logic [CH_W-1:0]   idx_r, idx_nxt;
  action_t           act_r, act_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic              ch_ok_r, ch_ok_nxt;
  logic              per_r, per_nxt;
  logic              clr_r, clr_nxt;
  logic              en_r, en_nxt;
  logic              pzero_r, pzero_nxt;
  logic [PROD_W-1:0] q_r, q_nxt;
  logic [IRQ_W-1:0]  irq_r, irq_nxt;
  logic [NUM_CHANNELS-1:0] vld_r;
  logic              rd_vld_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic              in_fire, out_fire;
  action_t           in_act;
  logic [1:0]        in_ch;
  logic [31:0]       in_period;
  logic              in_ch_ok;

  logic              ram_we;
  logic [CH_W-1:0]   ram_wa, ram_ra;
  logic [ENTRY_W-1:0] ram_rd;
  entry_t            cur, upd;
  logic [31:0]       cnt1;
  logic              hit;
  logic [1:0]        res_status;
  logic [31:0]       res_count;
  logic              res_bit;
  logic [IRQ_W-1:0]  irq_bit;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign in_act    = action_t'(in_tdata[2:0]);
  assign in_ch     = in_tdata[4:3];
  assign in_period = in_tdata[36:5];
  assign in_ch_ok  = ({30'd0, in_ch} < 32'(NUM_CHANNELS));

  // entry seen by the modify step, never-written entries read as zero
  assign cur     = rd_vld_r ? entry_t'(ram_rd) : '0;
  assign cnt1    = cur.count + 32'd1;
  assign hit     = (cnt1 >= cur.limit);
  assign irq_bit = (hit && cur.enable) ? (IRQ_W'(1) << idx_r) : '0;

  // request sequencer and read-modify-write of one entry
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    act_nxt       = act_r;
    ch_nxt        = ch_r;
    ch_ok_nxt     = ch_ok_r;
    per_nxt       = per_r;
    clr_nxt       = clr_r;
    en_nxt        = en_r;
    pzero_nxt     = pzero_r;
    q_nxt         = q_r;
    irq_nxt       = irq_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    div_req.start    = 1'b0;
    div_req.dividend = PROD_W'(in_period) * PROD_W'(TICK_FREQ_HZ);
    ram_we        = 1'b0;
    ram_wa        = ch_r;
    ram_ra        = (act_r == ACT_TICK) ? idx_r : ch_r;
    upd           = cur;
    res_status    = ST_OK;
    res_count     = '0;
    res_bit       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt   = in_act;
          ch_nxt    = CH_W'(in_ch);
          ch_ok_nxt = in_ch_ok;
          per_nxt   = in_tdata[37];
          clr_nxt   = in_tdata[38];
          en_nxt    = in_tdata[39];
          pzero_nxt = (in_period == 32'd0);
          idx_nxt   = '0;
          irq_nxt   = '0;
          if (in_act == ACT_SET_MATCH && in_period != 32'd0 && in_ch_ok) begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          q_nxt     = div_rsp.quot;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // read issues every cycle here; move on once the result slot is free
        if (!out_valid_r) begin
          state_nxt = (act_r == ACT_TICK) ? S_TICK : S_APPLY;
        end
      end
      S_TICK: begin
        ram_ra = idx_r + CH_W'(1);
        ram_wa = idx_r;
        ram_we = 1'b1;
        upd.count = cnt1;
        if (hit) begin
          upd.flag = 1'b1;
          if (cur.periodic) begin
            upd.count = '0;
          end else begin
            upd.enable = 1'b0;
          end
        end
        irq_nxt = irq_r | irq_bit;
        if (idx_r == CH_W'(NUM_CHANNELS - 1)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, irq_r | irq_bit, 1'b0, 32'd0, ST_OK};
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + CH_W'(1);
        end
      end
      S_APPLY: begin
        if (ch_ok_r) begin
          unique case (act_r)
            ACT_START: begin
              upd.count = '0;
              ram_we    = 1'b1;
            end
            ACT_READ: begin
              res_count = cur.count;
            end
            ACT_SET_MATCH: begin
              priority if (pzero_r) begin
                upd.enable   = 1'b0;
                upd.flag     = 1'b0;
                upd.periodic = 1'b0;
                ram_we       = 1'b1;
              end else if (|q_r[PROD_W-1:32]) begin
                res_status = ST_TOO_LONG;
              end else if (q_r[31:0] == 32'd0) begin
                res_status = ST_TOO_SHORT;
              end else begin
                upd.limit    = q_r[31:0];
                upd.periodic = per_r;
                upd.flag     = 1'b0;
                upd.count    = '0;
                upd.enable   = 1'b1;
                ram_we       = 1'b1;
              end
            end
            ACT_GET_FLAG: begin
              res_bit = cur.flag;
              if (clr_r) begin
                upd.flag = 1'b0;
                ram_we   = 1'b1;
              end
            end
            ACT_SET_EN: begin
              res_bit    = cur.enable;
              upd.enable = en_r;
              ram_we     = 1'b1;
            end
            ACT_GET_EN: begin
              res_bit = cur.enable;
            end
            default: begin
            end
          endcase
        end
        out_valid_nxt = 1'b1;
        out_data_nxt  = {1'b0, IRQ_W'(0), res_bit, res_count, res_status};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        vld_r[ram_wa] <= 1'b1;
      end
    end
  end

  // request fields, accumulators and result payload
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    act_r      <= act_nxt;
    ch_r       <= ch_nxt;
    ch_ok_r    <= ch_ok_nxt;
    per_r      <= per_nxt;
    clr_r      <= clr_nxt;
    en_r       <= en_nxt;
    pzero_r    <= pzero_nxt;
    q_r        <= q_nxt;
    irq_r      <= irq_nxt;
    out_data_r <= out_data_nxt;
    rd_vld_r   <= vld_r[ram_ra];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  vtb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_CHANNELS)
  ) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ENTRY_W'(upd)),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  vtb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // entry writes only come from the modify steps
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_APPLY || state_r == S_TICK))
    else $error("entry write outside a modify step");

  // a command result in the apply step is only made when the result slot is empty
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> !out_valid_r)
    else $error("result produced over a pending result");

  // the divider only reports back while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider result with no waiting request");

  // an accepted request leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after a request");

endmodule
